>>> design/blit_pixel_expand_colorkey_top_assert.svh
// Assertion macros for the blit pixel expand and color key block.
`ifndef BLIT_PIXEL_EXPAND_COLORKEY_TOP_ASSERT_SVH
`define BLIT_PIXEL_EXPAND_COLORKEY_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BPXE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define BPXE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bpxe_pkg.sv
// Shared types and constants of the blit pixel expand and color key block.
`default_nettype none
package bpxe_pkg;

  localparam int unsigned RAW_W  = 32;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned RGB_W  = 3 * CH_W;
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Reciprocal scaling: floor(x * 255 / d) = (x * 255 * ceil(2^S / d)) >> S
  localparam int unsigned SCALE_SHIFT = 23;
  localparam logic [31:0] R5_MULT = 32'(255 * ((2 ** SCALE_SHIFT + 30) / 31));
  localparam logic [31:0] G6_MULT = 32'(255 * ((2 ** SCALE_SHIFT + 62) / 63));

  typedef enum logic [1:0] {
    DEPTH_8  = 2'd0,
    DEPTH_16 = 2'd1,
    DEPTH_24 = 2'd2,
    DEPTH_32 = 2'd3
  } bpxe_depth_e;

  typedef enum logic {
    REQ_PIXEL   = 1'b0,
    REQ_PALETTE = 1'b1
  } bpxe_req_e;

  typedef enum logic [2:0] {
    REG_PIXEL_DEPTH    = 3'd0,
    REG_FILL_MODE      = 3'd1,
    REG_KEY_ENABLE     = 3'd2,
    REG_KEY_LOW        = 3'd3,
    REG_KEY_HIGH       = 3'd4,
    REG_SURFACE_WIDTH  = 3'd5,
    REG_SURFACE_HEIGHT = 3'd6,
    REG_PALETTE_MODE   = 3'd7
  } bpxe_reg_e;

  typedef struct packed {
    bpxe_depth_e        depth;
    logic               fill;
    logic               key_en;
    logic [RAW_W-1:0]   key_lo;
    logic [RAW_W-1:0]   key_hi;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic               pal_mode;
  } bpxe_cfg_t;

  typedef struct packed {
    logic             keep;
    logic             pal_hit;
    logic [RGB_W-1:0] raw_rgb;
    logic [CH_W-1:0]  r565;
    logic [CH_W-1:0]  g565;
    logic [CH_W-1:0]  b565;
  } bpxe_s2_t;

endpackage
`default_nettype wire

>>> design/blit_pixel_expand_colorkey_top.sv
// Top level of the blit pixel expand and color key block.
// One transaction is accepted every clock unless in_stall_o is high, and each gives
// exactly one result, carried through the stages in order: stage one holds the accepted
// transaction, stage two holds the drop decision, the RGB565 scaling products and
// the palette RAM read (single port, shared with palette writes), stage three is
// the output register. An occupied stage holds only while every later stage is
// occupied and the output stalls; empty stages keep filling. Palette entries read
// before they are written return unspecified colors. Configuration must be written
// over the register port only while idle; the block itself does not enforce this.
`default_nettype none
module blit_pixel_expand_colorkey_top #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned COORD_BITS      = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bpxe_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bpxe_pkg::DATA_W-1:0]    pwdata,
  output logic      [bpxe_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           req_type_i,
  input  wire logic [31:0]                    raw_value_i,
  input  wire logic                           covered_i,
  input  wire logic signed [COORD_BITS-1:0]   src_col_i,
  input  wire logic signed [COORD_BITS-1:0]   src_row_i,
  input  wire logic [7:0]                     entry_index_i,
  input  wire logic [23:0]                    entry_rgb_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                pixel_written_o,
  output logic      [7:0]                     red_o,
  output logic      [7:0]                     green_o,
  output logic      [7:0]                     blue_o
);
  import bpxe_pkg::*;

  `include "blit_pixel_expand_colorkey_top_assert.svh"

  bpxe_cfg_t cfg_q;
  bpxe_reg_e reg_sel;
  logic      cfg_wr;

  logic      v1_q, v2_q, v3_q;
  logic      adv1, adv2, adv3;
  bpxe_s2_t  s2;
  logic [RGB_W-1:0] pal_rgb;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = bpxe_reg_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth    <= DEPTH_8;
      cfg_q.fill     <= 1'b0;
      cfg_q.key_en   <= 1'b0;
      cfg_q.key_lo   <= '0;
      cfg_q.key_hi   <= '0;
      cfg_q.width    <= SIZE_W'(1);
      cfg_q.height   <= SIZE_W'(1);
      cfg_q.pal_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PIXEL_DEPTH:    cfg_q.depth    <= bpxe_depth_e'(pwdata[1:0]);
        REG_FILL_MODE:      cfg_q.fill     <= pwdata[0];
        REG_KEY_ENABLE:     cfg_q.key_en   <= pwdata[0];
        REG_KEY_LOW:        cfg_q.key_lo   <= pwdata;
        REG_KEY_HIGH:       cfg_q.key_hi   <= pwdata;
        REG_SURFACE_WIDTH:  cfg_q.width    <= pwdata[SIZE_W-1:0];
        REG_SURFACE_HEIGHT: cfg_q.height   <= pwdata[SIZE_W-1:0];
        REG_PALETTE_MODE:   cfg_q.pal_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PIXEL_DEPTH:    prdata = DATA_W'(cfg_q.depth);
      REG_FILL_MODE:      prdata = DATA_W'(cfg_q.fill);
      REG_KEY_ENABLE:     prdata = DATA_W'(cfg_q.key_en);
      REG_KEY_LOW:        prdata = cfg_q.key_lo;
      REG_KEY_HIGH:       prdata = cfg_q.key_hi;
      REG_SURFACE_WIDTH:  prdata = DATA_W'(cfg_q.width);
      REG_SURFACE_HEIGHT: prdata = DATA_W'(cfg_q.height);
      REG_PALETTE_MODE:   prdata = DATA_W'(cfg_q.pal_mode);
      default:            prdata = '0;
    endcase
  end

  // Pipeline control: a stage advances when empty or when the next one advances
  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  bpxe_qualify #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .COORD_BITS      (COORD_BITS)
  ) u_qualify (
    .clk_i         (clk_i),
    .adv1_i        (adv1),
    .adv2_i        (adv2),
    .v1_i          (v1_q),
    .cfg_i         (cfg_q),
    .req_type_i    (bpxe_req_e'(req_type_i)),
    .raw_value_i   (raw_value_i),
    .covered_i     (covered_i),
    .src_col_i     (src_col_i),
    .src_row_i     (src_row_i),
    .entry_index_i (entry_index_i),
    .entry_rgb_i   (entry_rgb_i),
    .s2_o          (s2),
    .pal_rgb_o     (pal_rgb)
  );

  bpxe_expand u_expand (
    .clk_i     (clk_i),
    .adv3_i    (adv3),
    .cfg_i     (cfg_q),
    .s2_i      (s2),
    .pal_rgb_i (pal_rgb),
    .written_o (pixel_written_o),
    .red_o     (red_o),
    .green_o   (green_o),
    .blue_o    (blue_o)
  );

  assign out_valid_o = v3_q;

  `BPXE_ASSERT_NOW(a_drop_black, clk_i, rst_ni, out_valid_o && !pixel_written_o,
    red_o == '0 && green_o == '0 && blue_o == '0, "dropped result carries color")
  `BPXE_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o,
    v1_q && v2_q && v3_q && out_stall_i, "input stalled while pipeline has room")
  `BPXE_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, v1_q && !adv2, v1_q,
    "stage one lost a held transaction")

endmodule
`default_nettype wire

>>> design/bpxe_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bpxe_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> design/bpxe_qualify.sv
// Input stage, drop checks, RGB565 scaling and palette access.
`default_nettype none
module bpxe_qualify #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned COORD_BITS      = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           adv1_i,
  input  wire logic                           adv2_i,
  input  wire logic                           v1_i,
  input  wire bpxe_pkg::bpxe_cfg_t            cfg_i,
  input  wire bpxe_pkg::bpxe_req_e            req_type_i,
  input  wire logic [bpxe_pkg::RAW_W-1:0]     raw_value_i,
  input  wire logic                           covered_i,
  input  wire logic [COORD_BITS-1:0]          src_col_i,
  input  wire logic [COORD_BITS-1:0]          src_row_i,
  input  wire logic [bpxe_pkg::IDX_W-1:0]     entry_index_i,
  input  wire logic [bpxe_pkg::RGB_W-1:0]     entry_rgb_i,
  output bpxe_pkg::bpxe_s2_t                  s2_o,
  output logic      [bpxe_pkg::RGB_W-1:0]     pal_rgb_o
);
  import bpxe_pkg::*;

  localparam int unsigned PAL_ADDR_W = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CMP_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
  localparam logic [IDX_W:0] PAL_LIMIT = (IDX_W + 1)'(PALETTE_ENTRIES);

  bpxe_req_e             req_q;
  logic [RAW_W-1:0]      raw_q;
  logic                  cov_q;
  logic [COORD_BITS-1:0] col_q;
  logic [COORD_BITS-1:0] row_q;
  logic [IDX_W-1:0]      idx_q;
  logic [RGB_W-1:0]      rgb_q;
  bpxe_s2_t              s2_d;
  bpxe_s2_t              s2_q;

  logic                  is_pix;
  logic                  in_bounds;
  logic                  key_hit;
  logic                  wr_hit;
  logic                  rd_hit;
  logic                  ram_en;
  logic                  ram_we;
  logic [PAL_ADDR_W-1:0] ram_addr;
  logic [31:0]           r_prod;
  logic [31:0]           g_prod;
  logic [31:0]           b_prod;

  always_ff @(posedge clk_i) begin
    if (adv1_i) begin
      req_q <= req_type_i;
      raw_q <= raw_value_i;
      cov_q <= covered_i;
      col_q <= src_col_i;
      row_q <= src_row_i;
      idx_q <= entry_index_i;
      rgb_q <= entry_rgb_i;
    end
  end

  always_comb begin
    is_pix    = (req_q == REQ_PIXEL);
    in_bounds = !col_q[COORD_BITS-1] && !row_q[COORD_BITS-1]
                && (CMP_W'(col_q) < CMP_W'(cfg_i.width))
                && (CMP_W'(row_q) < CMP_W'(cfg_i.height));
    key_hit   = cfg_i.key_en && (raw_q >= cfg_i.key_lo) && (raw_q <= cfg_i.key_hi);
    wr_hit    = ({1'b0, idx_q} < PAL_LIMIT);
    rd_hit    = ({1'b0, raw_q[IDX_W-1:0]} < PAL_LIMIT);
    r_prod    = 32'(raw_q[15:11]) * R5_MULT;
    g_prod    = 32'(raw_q[10:5]) * G6_MULT;
    b_prod    = 32'(raw_q[4:0]) * R5_MULT;

    s2_d.keep    = is_pix && cov_q && (cfg_i.fill || (in_bounds && !key_hit));
    s2_d.pal_hit = rd_hit;
    s2_d.raw_rgb = raw_q[RGB_W-1:0];
    s2_d.r565    = r_prod[SCALE_SHIFT +: CH_W];
    s2_d.g565    = g_prod[SCALE_SHIFT +: CH_W];
    s2_d.b565    = b_prod[SCALE_SHIFT +: CH_W];

    ram_en   = adv2_i && v1_i;
    ram_we   = !is_pix && wr_hit;
    ram_addr = is_pix ? raw_q[PAL_ADDR_W-1:0] : idx_q[PAL_ADDR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv2_i) begin
      s2_q <= s2_d;
    end
  end

  bpxe_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (rgb_q),
    .rdata_o (pal_rgb_o)
  );

  assign s2_o = s2_q;

endmodule
`default_nettype wire

>>> design/bpxe_expand.sv
// Output stage: color selection by source depth and result register.
`default_nettype none
module bpxe_expand (
  input  wire logic                       clk_i,
  input  wire logic                       adv3_i,
  input  wire bpxe_pkg::bpxe_cfg_t        cfg_i,
  input  wire bpxe_pkg::bpxe_s2_t         s2_i,
  input  wire logic [bpxe_pkg::RGB_W-1:0] pal_rgb_i,
  output logic                            written_o,
  output logic      [bpxe_pkg::CH_W-1:0]  red_o,
  output logic      [bpxe_pkg::CH_W-1:0]  green_o,
  output logic      [bpxe_pkg::CH_W-1:0]  blue_o
);
  import bpxe_pkg::*;

  logic            written_d, written_q;
  logic [CH_W-1:0] red_d, red_q;
  logic [CH_W-1:0] green_d, green_q;
  logic [CH_W-1:0] blue_d, blue_q;
  logic [CH_W-1:0] grey;

  always_comb begin
    grey      = s2_i.raw_rgb[CH_W-1:0];
    written_d = s2_i.keep;
    red_d     = '0;
    green_d   = '0;
    blue_d    = '0;
    if (s2_i.keep) begin
      case (cfg_i.depth) inside
        DEPTH_8: begin
          if (!cfg_i.pal_mode) begin
            red_d   = grey;
            green_d = grey;
            blue_d  = grey;
          end else if (s2_i.pal_hit) begin
            red_d   = pal_rgb_i[2*CH_W +: CH_W];
            green_d = pal_rgb_i[CH_W +: CH_W];
            blue_d  = pal_rgb_i[0 +: CH_W];
          end
        end
        DEPTH_16: begin
          red_d   = s2_i.r565;
          green_d = s2_i.g565;
          blue_d  = s2_i.b565;
        end
        DEPTH_24, DEPTH_32: begin
          red_d   = s2_i.raw_rgb[2*CH_W +: CH_W];
          green_d = s2_i.raw_rgb[CH_W +: CH_W];
          blue_d  = s2_i.raw_rgb[0 +: CH_W];
        end
        default: begin
          red_d   = '0;
          green_d = '0;
          blue_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3_i) begin
      written_q <= written_d;
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
    end
  end

  assign written_o = written_q;
  assign red_o     = red_q;
  assign green_o   = green_q;
  assign blue_o    = blue_q;

endmodule
`default_nettype wire
